/* sv/tta_pkg.sv */
// tta_pkg: shared constants, codes and types of the timed task queue.
// No dependencies; imported by every module of the block.
package tta_pkg;

	localparam int QUEUE_DEPTH    = 16;
	localparam int MAX_RESULTS    = 16;
	localparam int QIDX_W         = $clog2(QUEUE_DEPTH);
	localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);
	localparam int NCNT_W         = $clog2(MAX_RESULTS + 1);
	// power of two, so the FIFO pointers wrap on their own
	localparam int CMD_FIFO_DEPTH = 2;
	localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
	localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

	localparam int STEP_W = 10;
	localparam logic [STEP_W-1:0] STEP_RESET = 10'd10;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	localparam logic [1:0] REQ_SCHED = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [1:0] RES_DISPATCH = 2'd0;
	localparam logic [1:0] RES_ACCEPT   = 2'd1;
	localparam logic [1:0] RES_REJECT   = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [3:0]         module_id;
		logic [7:0]         task_id;
		logic signed [32:0] time_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [3:0]  out_module;
		logic [7:0]  out_task;
		logic [31:0] out_due_time;
		logic        last_result;
	} res_t;

endpackage

/* sv/tta_front.sv */
// tta_front: accepts input transactions, drops unused request codes and
// registers one classified command. Depends on tta_pkg.
module tta_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tta_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic [1:0]                    s_tuser,
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output tta_pkg::cmd_t                 cmd
);
	import tta_pkg::*;

	logic valid_q;
	cmd_t cmd_q;
	logic take;
	logic known;

	assign s_tready  = !valid_q || cmd_ready;
	assign take      = s_tvalid && s_tready;
	assign known     = (s_tuser == REQ_SCHED) || (s_tuser == REQ_TICK) ||
	                   (s_tuser == REQ_CLEAR);
	assign cmd_valid = valid_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= known;
		end else if (cmd_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q.kind       <= s_tuser;
			cmd_q.module_id  <= s_tdata[3:0];
			cmd_q.task_id    <= s_tdata[11:4];
			cmd_q.time_value <= s_tdata[44:12];
		end
	end

endmodule

/* sv/tta_cmd_fifo.sv */
// tta_cmd_fifo: short command queue between front and back.
// Depends on tta_pkg.
module tta_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  tta_pkg::cmd_t wr_cmd,
	output logic          rd_valid,
	input  logic          rd_pop,
	output tta_pkg::cmd_t rd_cmd
);
	import tta_pkg::*;

	cmd_t                 mem_q [CMD_FIFO_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] cnt_q;
	logic                 push;
	logic                 pop;

	assign wr_ready = cnt_q != CMD_CNT_W'(CMD_FIFO_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_cmd;
	end

endmodule

/* sv/tta_back.sv */
// tta_back: sorted task store, millisecond clock and dispatch sequencer,
// with the output register. Depends on tta_pkg.
module tta_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [tta_pkg::STEP_W-1:0] tick_step,
	input  logic                    cmd_valid,
	output logic                    cmd_pop,
	input  tta_pkg::cmd_t           cmd,
	output logic                    res_valid,
	input  logic                    res_ready,
	output tta_pkg::res_t           res
);
	import tta_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DISP = 2'd1;

	logic [1:0]        state_q;
	logic [63:0]       now_q;
	logic [CNT_W-1:0]  count_q;
	logic [NCNT_W-1:0] n_q;
	logic [31:0]       due_q  [QUEUE_DEPTH];
	logic [3:0]        mod_q  [QUEUE_DEPTH];
	logic [7:0]        task_q [QUEUE_DEPTH];
	logic              ovalid_q;
	res_t              ores_q;

	logic              out_free;
	logic [31:0]       new_due;
	logic              full;
	logic              le [QUEUE_DEPTH];
	logic              head_due;
	logic              next_due;
	logic              do_insert;
	logic              do_pop;
	logic              emit;
	res_t              emit_res;

	assign out_free  = !ovalid_q || res_ready;
	assign res_valid = ovalid_q;
	assign res       = ores_q;

	assign new_due = cmd.time_value[32] ? (now_q[31:0] - cmd.time_value[31:0])
	                                    : cmd.time_value[31:0];
	assign full    = count_q >= CNT_W'(QUEUE_DEPTH);

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			le[i] = (CNT_W'(i) < count_q) && (due_q[i] <= new_due);
		end
	end

	assign head_due = (count_q != '0) && (n_q < NCNT_W'(MAX_RESULTS)) &&
	                  ({32'd0, due_q[0]} <= now_q);
	assign next_due = (count_q > CNT_W'(1)) &&
	                  ((n_q + 1'b1) < NCNT_W'(MAX_RESULTS)) &&
	                  ({32'd0, due_q[1]} <= now_q);

	always_comb begin
		cmd_pop   = 1'b0;
		do_insert = 1'b0;
		do_pop    = 1'b0;
		emit      = 1'b0;
		emit_res  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					priority if (cmd.kind == REQ_SCHED) begin
						if (out_free) begin
							cmd_pop   = 1'b1;
							emit      = 1'b1;
							do_insert = !full;
							emit_res.result_kind  = full ? RES_REJECT : RES_ACCEPT;
							emit_res.out_module   = cmd.module_id;
							emit_res.out_task     = cmd.task_id;
							emit_res.out_due_time = new_due;
							emit_res.last_result  = 1'b1;
						end
					end else begin
						cmd_pop = 1'b1;
					end
				end
			end
			ST_DISP: begin
				if (head_due && out_free) begin
					emit   = 1'b1;
					do_pop = 1'b1;
					emit_res.result_kind  = RES_DISPATCH;
					emit_res.out_module   = mod_q[0];
					emit_res.out_task     = task_q[0];
					emit_res.out_due_time = due_q[0];
					emit_res.last_result  = !next_due;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			now_q    <= '0;
			count_q  <= '0;
			n_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (res_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						priority if (cmd.kind == REQ_TICK) begin
							now_q   <= now_q + {54'd0, tick_step};
							n_q     <= '0;
							state_q <= ST_DISP;
						end else if (cmd.kind == REQ_CLEAR) begin
							count_q <= '0;
						end else if (do_insert) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_DISP: begin
					if (!head_due) begin
						state_q <= ST_IDLE;
					end else if (do_pop) begin
						count_q <= count_q - 1'b1;
						n_q     <= n_q + 1'b1;
						if (!next_due) state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// entries with due time <= new stay put; the first later one takes the
	// new task and the rest move up one slot
	always_ff @(posedge clk) begin
		if (emit) ores_q <= emit_res;
		if (do_insert) begin
			if (!le[0]) begin
				due_q[0]  <= new_due;
				mod_q[0]  <= cmd.module_id;
				task_q[0] <= cmd.task_id;
			end
			for (int i = 1; i < QUEUE_DEPTH; i++) begin
				if (!le[i]) begin
					if (le[i-1]) begin
						due_q[i]  <= new_due;
						mod_q[i]  <= cmd.module_id;
						task_q[i] <= cmd.task_id;
					end else begin
						due_q[i]  <= due_q[i-1];
						mod_q[i]  <= mod_q[i-1];
						task_q[i] <= task_q[i-1];
					end
				end
			end
		end else if (do_pop) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				due_q[i]  <= due_q[i+1];
				mod_q[i]  <= mod_q[i+1];
				task_q[i] <= task_q[i+1];
			end
		end
	end

endmodule

/* sv/timed_task_queue.sv */
// timed_task_queue: top level of the sorted timed task queue.
// Depends on tta_pkg, tta_front, tta_cmd_fifo and tta_back.
//
// Input stream s_*: tuser carries the request (schedule, tick, clear), tdata
// the task fields. Output stream m_*: tuser carries the result kind, tlast
// marks the final result of one request, tdata the task fields.
// cfg_*: writes tick_step_ms (ms added per tick); always ready.
//
// A request passes the front register and a two-entry command FIFO, so up
// to three requests are taken while the back end is busy or stalled.
// Schedule: one result, via the front register, the FIFO and the output
// register; the slot row shifts to insert as the result is registered.
// Tick: the clock add first, then one dispatched task per cycle while the
// output register is free (at most 16), until no further task is due.
// Clear: empties the queue, no result.
// Unused request code 3 is dropped at the front.
// When m_tready is low the result stays in the output register and the
// sequencer waits; the FIFO then fills and s_tready falls.
// Reset empties the queue, sets the clock to zero and the step to 10 ms.
module timed_task_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [3:0] module_id, [11:4] task_id, [44:12] time_value, [47:45] zero
	input  logic [tta_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [1:0] req_type
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [3:0] out_module, [11:4] out_task, [43:12] out_due_time, [47:44] zero
	output logic [tta_pkg::OUT_TDATA_W-1:0] m_tdata,
	// [1:0] result_kind
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tta_pkg::STEP_W-1:0]      cfg_data
);
	import tta_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              f_valid;
	logic              f_ready;
	cmd_t              f_cmd;
	logic              q_valid;
	logic              q_pop;
	cmd_t              q_cmd;
	res_t              res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_valid) begin
			step_q <= cfg_data;
		end
	end

	tta_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	tta_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_cmd   (f_cmd),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_cmd   (q_cmd)
	);

	tta_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_step (step_q),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cmd       (q_cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tuser = res.result_kind;
	assign m_tlast = res.last_result;
	assign m_tdata = {4'd0, res.out_due_time, res.out_task, res.out_module};

endmodule
